[hw/rtl/fsria_pkg.sv]
// Shared types and constants for the FSR indirect addressing unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fsria_pkg;

    // Port field widths (fixed by the bus)
    localparam int ADDR_W    = 12;
    localparam int DATA_W    = 8;
    localparam int OUTC_W    = 3;
    localparam int PAD_W     = 16;   // widest internal address, for byte slicing

    // Stream word layout
    localparam int IN_TDATA_W  = 32;
    localparam int IN_ADDR_LSB = 0;
    localparam int IN_DATA_LSB = IN_ADDR_LSB + ADDR_W;
    localparam int IN_W_LSB    = IN_DATA_LSB + DATA_W;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - ADDR_W - DATA_W;

    // Parameter defaults
    localparam int ADDR_BITS_DEF    = 12;
    localparam int NUM_POINTERS_DEF = 3;
    localparam int NUM_BASES        = 3;
    localparam int CHAN_W           = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LAST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN0_BASE   = 3'd2;

    localparam logic [ADDR_W-1:0] WINDOW_FIRST_RST = 12'd3968;
    localparam logic [ADDR_W-1:0] WINDOW_LAST_RST  = 12'd4095;

    // Channel layout: offsets from the base address
    localparam int NUM_OFF = 7;
    localparam int NUM_MODES = 5;
    localparam logic [2:0] OFF_LO      = 3'd0;
    localparam logic [2:0] OFF_HI      = 3'd1;
    localparam logic [2:0] OFF_PLUSW   = 3'd2;
    localparam logic [2:0] OFF_PREINC  = 3'd3;
    localparam logic [2:0] OFF_POSTDEC = 3'd4;
    localparam logic [2:0] OFF_POSTINC = 3'd5;
    localparam logic [2:0] OFF_PLAIN   = 3'd6;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [2:0] {
        OUT_OUTSIDE    = 3'd0,
        OUT_DIRECT     = 3'd1,
        OUT_INDIRECT   = 3'd2,
        OUT_SUPPRESSED = 3'd3,
        OUT_PTR_BYTE   = 3'd4
    } outcome_t;

    typedef enum logic [2:0] {
        ACC_OUTSIDE,
        ACC_DIRECT,
        ACC_PLAIN,
        ACC_PREINC,
        ACC_POSTINC,
        ACC_POSTDEC,
        ACC_PLUSW,
        ACC_PTR_BYTE
    } kind_t;

    // Classified access, front to back
    typedef struct packed {
        kind_t              kind;
        logic [CHAN_W-1:0]  chan;
        logic               hi_byte;
        logic               wr;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        logic [DATA_W-1:0]  w_value;
    } item_t;

    function automatic logic [ADDR_W-1:0] base_reset(input int ch);
        logic [ADDR_W-1:0] r;
        case (ch)
            0:       r = 12'd4073;
            1:       r = 12'd4065;
            default: r = 12'd4057;
        endcase
        return r;
    endfunction

    // Match priority among indirect modes: plain, preinc, postinc, postdec, plus-W
    function automatic logic [2:0] mode_off(input int m);
        logic [2:0] r;
        case (m)
            0:       r = OFF_PLAIN;
            1:       r = OFF_PREINC;
            2:       r = OFF_POSTINC;
            3:       r = OFF_POSTDEC;
            default: r = OFF_PLUSW;
        endcase
        return r;
    endfunction

    function automatic kind_t mode_kind(input int m);
        kind_t r;
        case (m)
            0:       r = ACC_PLAIN;
            1:       r = ACC_PREINC;
            2:       r = ACC_POSTINC;
            3:       r = ACC_POSTDEC;
            default: r = ACC_PLUSW;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/fsria_front.sv]
// Front end: configuration registers, channel address table and access classifier.
// Depends on fsria_pkg.
`timescale 1ns / 1ps

module fsria_front #(
    parameter int ADDR_BITS = fsria_pkg::ADDR_BITS_DEF,
    parameter int NUM_CH    = fsria_pkg::NUM_BASES
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [fsria_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fsria_pkg::ADDR_W-1:0]           cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [fsria_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                   s_tuser,
    input  logic                                   q_full,
    output logic                                   q_push,
    output fsria_pkg::item_t                       q_item,
    output logic [NUM_CH-1:0][fsria_pkg::NUM_OFF-1:0][ADDR_BITS-1:0] chan_addr
);
    import fsria_pkg::*;

    logic [ADDR_BITS-1:0] window_first_reg;
    logic [ADDR_BITS-1:0] window_last_reg;
    logic [NUM_CH-1:0][NUM_OFF-1:0][ADDR_BITS-1:0] chan_addr_reg;
    logic [ADDR_BITS-1:0] cfg_val;
    logic [ADDR_BITS-1:0] acc_addr;
    logic                 found;

    assign cfg_val  = ADDR_BITS'(cfg_data);
    assign acc_addr = ADDR_BITS'(s_tdata[IN_ADDR_LSB +: ADDR_W]);

    // A base write stores the whole layout of that channel, already wrapped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_first_reg <= ADDR_BITS'(WINDOW_FIRST_RST);
            window_last_reg  <= ADDR_BITS'(WINDOW_LAST_RST);
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                for (int off = 0; off < NUM_OFF; off++)
                begin
                    chan_addr_reg[ch][off] <= ADDR_BITS'(base_reset(ch)) + ADDR_BITS'(off);
                end
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_WINDOW_FIRST)
            begin
                window_first_reg <= cfg_val;
            end
            if (cfg_index == CFG_WINDOW_LAST)
            begin
                window_last_reg <= cfg_val;
            end
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                if (cfg_index == CFG_CHAN0_BASE + CFG_IDX_W'(ch))
                begin
                    for (int off = 0; off < NUM_OFF; off++)
                    begin
                        chan_addr_reg[ch][off] <= cfg_val + ADDR_BITS'(off);
                    end
                end
            end
        end
    end

    always_comb
    begin
        q_item.kind    = ACC_DIRECT;
        q_item.chan    = '0;
        q_item.hi_byte = 1'b0;
        q_item.wr      = s_tuser;
        q_item.addr    = s_tdata[IN_ADDR_LSB +: ADDR_W];
        q_item.data    = s_tdata[IN_DATA_LSB +: DATA_W];
        q_item.w_value = s_tdata[IN_W_LSB +: DATA_W];
        found          = 1'b0;
        if (acc_addr < window_first_reg || acc_addr > window_last_reg)
        begin
            q_item.kind = ACC_OUTSIDE;
        end
        else
        begin
            // indirect addresses win over pointer bytes; lowest channel first
            for (int m = 0; m < NUM_MODES; m++)
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    if (!found && chan_addr_reg[ch][mode_off(m)] == acc_addr)
                    begin
                        found       = 1'b1;
                        q_item.kind = mode_kind(m);
                        q_item.chan = CHAN_W'(ch);
                    end
                end
            end
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                if (!found && chan_addr_reg[ch][OFF_LO] == acc_addr)
                begin
                    found       = 1'b1;
                    q_item.kind = ACC_PTR_BYTE;
                    q_item.chan = CHAN_W'(ch);
                end
                else if (!found && chan_addr_reg[ch][OFF_HI] == acc_addr)
                begin
                    found          = 1'b1;
                    q_item.kind    = ACC_PTR_BYTE;
                    q_item.chan    = CHAN_W'(ch);
                    q_item.hi_byte = 1'b1;
                end
            end
        end
    end

    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full;
    assign chan_addr = chan_addr_reg;

endmodule

[hw/rtl/fsria_queue.sv]
// Two-entry queue of classified accesses between front and back.
// Depends on fsria_pkg.
`timescale 1ns / 1ps

module fsria_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fsria_pkg::item_t  push_item,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output fsria_pkg::item_t  head_item
);
    import fsria_pkg::*;

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid     = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;
    assign head_item = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step with count");

endmodule

[hw/rtl/fsria_back.sv]
// Back end: pointer registers, address generation, indirect suppression, output register.
// Depends on fsria_pkg.
`timescale 1ns / 1ps

module fsria_back #(
    parameter int ADDR_BITS = fsria_pkg::ADDR_BITS_DEF,
    parameter int NUM_CH    = fsria_pkg::NUM_BASES
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    input  fsria_pkg::item_t                       q_item,
    output logic                                   q_pop,
    input  logic [NUM_CH-1:0][fsria_pkg::NUM_OFF-1:0][ADDR_BITS-1:0] chan_addr,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output fsria_pkg::outcome_t                    outcome,
    output logic [fsria_pkg::ADDR_W-1:0]           target_address,
    output logic [fsria_pkg::DATA_W-1:0]           target_data
);
    import fsria_pkg::*;

    localparam logic [7:0] HIGH_MASK = 8'(((1 << ADDR_BITS) - 1) >> 8);

    logic [ADDR_BITS-1:0] ptr_reg [NUM_CH];
    logic                 out_valid_reg;
    outcome_t             outcome_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [DATA_W-1:0]    data_reg;

    logic [ADDR_BITS-1:0] p_cur;
    logic [ADDR_BITS-1:0] p_new;
    logic [ADDR_BITS-1:0] target;
    logic [ADDR_BITS-1:0] w_ext;
    logic [PAD_W-1:0]     w_pad;
    logic [PAD_W-1:0]     p_pad;
    logic [PAD_W-1:0]     p_wr_pad;
    logic [PAD_W-1:0]     p_new_pad;
    logic                 ptr_upd;
    logic                 is_ind;
    outcome_t             outcome_next;
    logic [ADDR_W-1:0]    addr_next;
    logic [DATA_W-1:0]    data_next;
    logic [DATA_W-1:0]    fwd_data;

    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        p_cur = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (q_item.chan == CHAN_W'(i))
            begin
                p_cur = ptr_reg[i];
            end
        end
        w_pad    = {{(PAD_W - DATA_W){q_item.w_value[DATA_W-1]}}, q_item.w_value};
        w_ext    = w_pad[ADDR_BITS-1:0];
        p_pad    = PAD_W'(p_cur);
        p_wr_pad = q_item.hi_byte ? {q_item.data & HIGH_MASK, p_pad[7:0]}
                                  : {p_pad[PAD_W-1:8], q_item.data};
        target   = p_cur;
        p_new    = p_cur;
        ptr_upd  = 1'b0;
        unique case (q_item.kind)
            ACC_PLAIN:
            begin
                ptr_upd = 1'b1;
            end
            ACC_PREINC:
            begin
                ptr_upd = 1'b1;
                p_new   = p_cur + 1'b1;
                target  = p_cur + 1'b1;
            end
            ACC_POSTINC:
            begin
                ptr_upd = 1'b1;
                p_new   = p_cur + 1'b1;
            end
            ACC_POSTDEC:
            begin
                ptr_upd = 1'b1;
                p_new   = p_cur - 1'b1;
            end
            ACC_PLUSW:
            begin
                ptr_upd = 1'b1;
                target  = p_cur + w_ext;
            end
            ACC_PTR_BYTE:
            begin
                ptr_upd = q_item.wr;
                if (q_item.wr)
                begin
                    p_new = p_wr_pad[ADDR_BITS-1:0];
                end
            end
            default:
            begin
                ptr_upd = 1'b0;
            end
        endcase
        p_new_pad = PAD_W'(p_new);

        is_ind = 1'b0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            for (int off = OFF_PLUSW; off <= OFF_PLAIN; off++)
            begin
                if (chan_addr[ch][off] == target)
                begin
                    is_ind = 1'b1;
                end
            end
        end

        fwd_data = q_item.wr ? q_item.data : '0;
        unique case (q_item.kind) inside
            ACC_OUTSIDE:
            begin
                outcome_next = OUT_OUTSIDE;
                addr_next    = '0;
                data_next    = '0;
            end
            ACC_DIRECT:
            begin
                outcome_next = OUT_DIRECT;
                addr_next    = ADDR_W'(ADDR_BITS'(q_item.addr));
                data_next    = fwd_data;
            end
            ACC_PLAIN, ACC_PREINC, ACC_POSTINC, ACC_POSTDEC, ACC_PLUSW:
            begin
                if (is_ind)
                begin
                    outcome_next = OUT_SUPPRESSED;
                    addr_next    = '0;
                    data_next    = '0;
                end
                else
                begin
                    outcome_next = OUT_INDIRECT;
                    addr_next    = ADDR_W'(target);
                    data_next    = fwd_data;
                end
            end
            default:
            begin
                outcome_next = OUT_PTR_BYTE;
                addr_next    = '0;
                data_next    = q_item.hi_byte ? (p_new_pad[15:8] & HIGH_MASK)
                                              : p_new_pad[7:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                ptr_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (ptr_upd && q_item.chan == CHAN_W'(i))
                    begin
                        ptr_reg[i] <= p_new;
                    end
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            outcome_reg <= outcome_next;
            addr_reg    <= addr_next;
            data_reg    <= data_next;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign outcome        = outcome_reg;
    assign target_address = addr_reg;
    assign target_data    = data_reg;

    a_preinc_step: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_item.kind == ACC_PREINC && q_item.chan == '0
        |=> ptr_reg[0] == $past(ptr_reg[0]) + 1'b1)
        else $error("preincrement did not advance pointer 0");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid_reg)
        else $error("popped access left no result");

    a_suppress_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (outcome_reg == OUT_SUPPRESSED || outcome_reg == OUT_OUTSIDE)
        |-> addr_reg == '0 && data_reg == '0)
        else $error("refused or suppressed word carries data");

    a_direct_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_item.kind == ACC_DIRECT |=> ptr_reg[0] == $past(ptr_reg[0]))
        else $error("direct access moved a pointer");

endmodule

[hw/rtl/fsr_indirect_addressing_unit.sv]
// Top level of the FSR indirect addressing unit: front classifier, queue, back end.
// Depends on fsria_pkg, fsria_front, fsria_queue, fsria_back.
`timescale 1ns / 1ps

// One bus access (read or write) per input word, one result word per access.
// The unit sustains one access per clock while m_tready keeps taking results: an
// accepted word is classified and written into the queue at the accept edge, and
// the back end resolves it and registers the result in the output register when
// it is popped, which happens as soon as that register is empty or being taken.
// The back end does the pointer add, indirect-target compare and pointer
// write-back of an access at the edge on which it is popped;
// back-to-back accesses to the same pointer see each other's updates with no
// gap. A two-word queue lets the input keep flowing while a result waits on
// m_tready. Configuration writes take effect at once and are meant to be made
// while no access is in flight. No start-up sweep is needed after reset.
module fsr_indirect_addressing_unit #(
    parameter int ADDR_BITS    = fsria_pkg::ADDR_BITS_DEF,
    parameter int NUM_POINTERS = fsria_pkg::NUM_POINTERS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [fsria_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsria_pkg::ADDR_W-1:0]         cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [11:0] bus_address, [19:12] write_byte, [27:20] w_value, [31:28] zero
    input  logic [fsria_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [0] action (1 = write)
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [11:0] target_address, [19:12] target_data, [23:20] zero
    output logic [fsria_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // [2:0] outcome
    output logic [fsria_pkg::OUTC_W-1:0]         m_tuser
);
    import fsria_pkg::*;

    localparam int NUM_CH = (NUM_POINTERS < NUM_BASES) ? NUM_POINTERS : NUM_BASES;

    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_valid;
    item_t                push_item;
    item_t                head_item;
    outcome_t             outcome;
    logic [ADDR_W-1:0]    target_address;
    logic [DATA_W-1:0]    target_data;
    logic [NUM_CH-1:0][NUM_OFF-1:0][ADDR_BITS-1:0] chan_addr;

    fsria_front #(
        .ADDR_BITS (ADDR_BITS),
        .NUM_CH    (NUM_CH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item),
        .chan_addr (chan_addr)
    );

    fsria_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_item (head_item)
    );

    fsria_back #(
        .ADDR_BITS (ADDR_BITS),
        .NUM_CH    (NUM_CH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (head_item),
        .q_pop          (q_pop),
        .chan_addr      (chan_addr),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .outcome        (outcome),
        .target_address (target_address),
        .target_data    (target_data)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, target_data, target_address};
    assign m_tuser = outcome;

endmodule
